>>> rtl/efcc_pkg.sv
// package for the edge flip clique check block
// holds opcodes, state machine type and the default vertex count
`timescale 1ns / 1ps
package efcc_pkg;
    localparam int VERTICES_DEF = 42;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TG_RD,
        ST_TG_WA,
        ST_TG_WB,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_SETUP,
        ST_A_RD,
        ST_A_LOAD,
        ST_B_RD,
        ST_B_TEST,
        ST_DONE
    } state_t;
endpackage

>>> rtl/edge_flip_clique_check.sv
// top level of the edge flip clique check block
// depends on efcc_pkg; holds the adjacency memory and the triangle search sequencer
`timescale 1ns / 1ps
// Graph adjacency store with a one-edge-flip safety test. A request is taken
// when start is high and busy is low. A write leaves busy low; a toggle
// passes through ST_TG_RD, ST_TG_WA and ST_TG_WB. A query with a vertex out
// of range or a self pair goes straight to ST_DONE. Any other query reads
// both rows, then runs a triangle search over the candidate set. For each
// candidate a (lowest first) one memory read gives its row. Then each
// remaining neighbour b of a costs one more read and one compare. A query
// holds busy until it is done, and it stops early when a triangle is found.
// The search is limited by the single-port adjacency memory, which gives one
// row per cycle. The answer appears on pair_is_edge and flip_safe for one
// cycle with done high. It cannot be held off. Write and toggle give no
// answer. The memory resets by valid bits, one per row, so no clearing pass
// is needed.
module edge_flip_clique_check #(
    parameter int VERTICES = efcc_pkg::VERTICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [5:0]          vertex_a,
    input  logic [5:0]          vertex_b,
    input  logic [VERTICES-1:0] row_bits,
    output logic                done,
    output logic                pair_is_edge,
    output logic                flip_safe
);
    localparam int IW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam logic [VERTICES-1:0] ROW_MASK = {VERTICES{1'b1}};
    localparam logic [VERTICES-1:0] ONE_BIT = {{(VERTICES-1){1'b0}}, 1'b1};

    // adjacency memory with per-row valid bits
    logic [VERTICES-1:0] mem [VERTICES];
    logic [VERTICES-1:0] vld_reg;
    logic [VERTICES-1:0] rd_raw_reg;
    logic                rd_vld_reg;
    logic [VERTICES-1:0] rd_data;
    logic                we;
    logic [IW-1:0]       waddr, raddr;
    logic [VERTICES-1:0] wdata;

    efcc_pkg::state_t    state_reg, state_next;
    logic [IW-1:0]       ia_reg, ia_next, ib_reg, ib_next;
    logic [VERTICES-1:0] ra_reg, ra_next;   // row of a; row of b for the last toggle write
    logic [VERTICES-1:0] m_reg, m_next;     // remaining candidates
    logic [VERTICES-1:0] r_reg, r_next;     // remaining neighbours of a
    logic                inv_reg, inv_next; // search in complement
    logic                edge_reg, edge_next;
    logic                keep_reg, keep_next;
    logic                done_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_raw_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr] && !(we && waddr == raddr);
        end
    end

    // invalid rows read as zero
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

    // row as seen by the search, complemented for edge deletion
    logic [VERTICES-1:0] srow;
    logic [VERTICES-1:0] one_ib;
    assign one_ib = {{(VERTICES-1){1'b0}}, 1'b1} << ib_reg;
    assign srow = inv_reg ? (ROW_MASK ^ one_ib ^ rd_data) : rd_data;

    // lowest set bit helpers
    logic [VERTICES-1:0] m_low, r_low;
    logic [IW-1:0]       m_idx, r_idx;
    always_comb
    begin
        m_low = m_reg & (~m_reg + ONE_BIT);
        r_low = r_reg & (~r_reg + ONE_BIT);
        m_idx = '0;
        r_idx = '0;
        for (int i = 0; i < VERTICES; i++)
        begin
            if (m_low[i]) m_idx = IW'(i);
            if (r_low[i]) r_idx = IW'(i);
        end
    end

    logic a_ok, b_ok;
    assign a_ok = {26'd0, vertex_a} < 32'(VERTICES);
    assign b_ok = {26'd0, vertex_b} < 32'(VERTICES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= efcc_pkg::ST_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg   <= ia_next;
        ib_reg   <= ib_next;
        ra_reg   <= ra_next;
        m_reg    <= m_next;
        r_reg    <= r_next;
        inv_reg  <= inv_next;
        edge_reg <= edge_next;
        keep_reg <= keep_next;
        pair_is_edge <= edge_next;
        flip_safe    <= keep_next;
    end

    assign busy = (state_reg != efcc_pkg::ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ia_next = ia_reg; ib_next = ib_reg; ra_next = ra_reg;
        m_next = m_reg; r_next = r_reg; inv_next = inv_reg;
        edge_next = edge_reg; keep_next = keep_reg;
        done_next = 1'b0;
        we = 1'b0; waddr = ia_reg; wdata = ra_reg; raddr = ia_reg;
        unique case (state_reg)
            efcc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ia_next = vertex_a[IW-1:0];
                    ib_next = vertex_b[IW-1:0];
                    case (opcode)
                        efcc_pkg::OP_WRITE:
                        begin
                            if (a_ok)
                            begin
                                we    = 1'b1;
                                waddr = vertex_a[IW-1:0];
                                wdata = row_bits & ~({{(VERTICES-1){1'b0}},
                                        1'b1} << vertex_a[IW-1:0]);
                            end
                        end
                        efcc_pkg::OP_TOGGLE:
                        begin
                            if (a_ok && b_ok && vertex_a != vertex_b)
                            begin
                                raddr = vertex_a[IW-1:0];
                                state_next = efcc_pkg::ST_TG_RD;
                            end
                        end
                        efcc_pkg::OP_QUERY:
                        begin
                            edge_next = 1'b0;
                            keep_next = 1'b0;
                            if (a_ok && b_ok && vertex_a != vertex_b)
                            begin
                                raddr = vertex_a[IW-1:0];
                                state_next = efcc_pkg::ST_Q_RDA;
                            end
                            else
                            begin
                                state_next = efcc_pkg::ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            efcc_pkg::ST_TG_RD:
            begin
                // row a arrives; start read of row b
                ra_next    = rd_data;
                raddr      = ib_reg;
                state_next = efcc_pkg::ST_TG_WA;
            end
            efcc_pkg::ST_TG_WA:
            begin
                we    = 1'b1;
                waddr = ia_reg;
                wdata = ra_reg ^ ({{(VERTICES-1){1'b0}}, 1'b1} << ib_reg);
                ra_next = rd_data;
                state_next = efcc_pkg::ST_TG_WB;
            end
            efcc_pkg::ST_TG_WB:
            begin
                we    = 1'b1;
                waddr = ib_reg;
                wdata = ra_reg ^ ({{(VERTICES-1){1'b0}}, 1'b1} << ia_reg);
                state_next = efcc_pkg::ST_IDLE;
            end
            efcc_pkg::ST_Q_RDA:
            begin
                ra_next    = rd_data;
                raddr      = ib_reg;
                state_next = efcc_pkg::ST_Q_RDB;
            end
            efcc_pkg::ST_Q_RDB:
            begin
                edge_next = ra_reg[ib_reg];
                inv_next  = ra_reg[ib_reg];
                if (ra_reg[ib_reg])
                begin
                    m_next = ROW_MASK ^ (ra_reg | rd_data
                             | ({{(VERTICES-1){1'b0}}, 1'b1} << ia_reg) | one_ib);
                end
                else
                begin
                    m_next = ra_reg & rd_data;
                end
                keep_next  = 1'b1;
                state_next = efcc_pkg::ST_Q_SETUP;
            end
            efcc_pkg::ST_Q_SETUP,
            efcc_pkg::ST_A_RD:
            begin
                // issue read of lowest candidate
                if (m_reg == '0)
                begin
                    state_next = efcc_pkg::ST_DONE;
                end
                else
                begin
                    raddr      = m_idx;
                    ib_next    = m_idx;
                    state_next = efcc_pkg::ST_A_LOAD;
                end
            end
            efcc_pkg::ST_A_LOAD:
            begin
                m_next = m_reg ^ m_low;
                r_next = srow & (m_reg ^ m_low);
                state_next = efcc_pkg::ST_B_RD;
            end
            efcc_pkg::ST_B_RD:
            begin
                if (r_reg == '0)
                begin
                    state_next = efcc_pkg::ST_A_RD;
                end
                else
                begin
                    raddr      = r_idx;
                    ib_next    = r_idx;
                    state_next = efcc_pkg::ST_B_TEST;
                end
            end
            efcc_pkg::ST_B_TEST:
            begin
                if ((srow & r_reg) != '0)
                begin
                    keep_next  = 1'b0;
                    state_next = efcc_pkg::ST_DONE;
                end
                else
                begin
                    r_next     = r_reg ^ r_low;
                    state_next = efcc_pkg::ST_B_RD;
                end
            end
            efcc_pkg::ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = efcc_pkg::ST_IDLE;
            end
            default: state_next = efcc_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // an answer only follows the end of a query
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == efcc_pkg::ST_DONE)
        else $error("done without query");
    // a self pair never reports an edge
    a_self: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efcc_pkg::ST_IDLE && start && opcode == efcc_pkg::OP_QUERY
         && vertex_a == vertex_b) |=> ##1 (done && !pair_is_edge && !flip_safe))
        else $error("self pair answered");
    // the memory is written only in idle or toggle states
    a_we: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == efcc_pkg::ST_IDLE || state_reg == efcc_pkg::ST_TG_WA
                || state_reg == efcc_pkg::ST_TG_WB))
        else $error("stray write");
`endif
endmodule

>>> verif/efcc_scoreboard.sv
// checker for the edge flip clique check block: tracks the graph, predicts query answers
// and compares them with the done strobes; depends on efcc_pkg
`timescale 1ns / 1ps
module efcc_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  vertex_a,
    input  logic [5:0]  vertex_b,
    input  logic [41:0] row_bits,
    input  logic        done,
    input  logic        pair_is_edge,
    input  logic        flip_safe,
    output int          errors,
    output int          outstanding,
    output int          answers,
    output int          edge_answers
);
    localparam int NV = 42;
    localparam logic [41:0] ALL_ROWS = '1;

    typedef struct packed {
        logic is_edge;
        logic keeps;
    } answer_t;

    logic [41:0] graph [NV];
    answer_t     answer_q [$];

    // search for a triangle inside cand, rows taken as stored, lowest vertex first
    function automatic bit has_triangle(input logic [41:0] rows [NV], input logic [41:0] cand);
        logic [41:0] m;
        logic [41:0] r;
        m = cand;
        for (int a = 0; a < NV; a++)
        begin
            if (m[a])
            begin
                m[a] = 1'b0;
                r = rows[a] & m;
                for (int b = 0; b < NV; b++)
                begin
                    if (r[b])
                    begin
                        if ((rows[b] & r) != '0)
                            return 1'b1;
                        r[b] = 1'b0;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // answer to a query request on the current graph
    function automatic answer_t predict_flip(input logic [5:0] u, input logic [5:0] v);
        answer_t     ans;
        logic [41:0] comp [NV];
        logic [41:0] cand;
        ans = '0;
        if (u < NV && v < NV && u != v)
        begin
            ans.is_edge = graph[u][v];
            if (ans.is_edge)
            begin
                for (int i = 0; i < NV; i++)
                begin
                    comp[i] = ALL_ROWS ^ (42'd1 << i);
                    comp[i] = comp[i] ^ graph[i];
                end
                cand = ~(graph[u] | graph[v] | (42'd1 << u) | (42'd1 << v));
                ans.keeps = !has_triangle(comp, cand);
            end
            else
                ans.keeps = !has_triangle(graph, graph[u] & graph[v]);
        end
        return ans;
    endfunction

    assign outstanding = answer_q.size();

    // follow accepted requests and compare answers
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
                graph[i] = '0;
            answer_q.delete();
            errors <= 0;
            answers <= 0;
            edge_answers <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                case (efcc_pkg::op_t'(opcode))
                    efcc_pkg::OP_WRITE:
                        if (vertex_a < NV)
                        begin
                            graph[vertex_a] = row_bits;
                            graph[vertex_a][vertex_a] = 1'b0;
                        end
                    efcc_pkg::OP_TOGGLE:
                        if (vertex_a < NV && vertex_b < NV && vertex_a != vertex_b)
                        begin
                            graph[vertex_a][vertex_b] = ~graph[vertex_a][vertex_b];
                            graph[vertex_b][vertex_a] = ~graph[vertex_b][vertex_a];
                        end
                    efcc_pkg::OP_QUERY:
                        answer_q.push_back(predict_flip(vertex_a, vertex_b));
                    default: ;
                endcase
            end
            if (done)
            begin
                got.is_edge = pair_is_edge;
                got.keeps = flip_safe;
                answers <= answers + 1;
                if (got.is_edge)
                    edge_answers <= edge_answers + 1;
                if (answer_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected answer edge=%b safe=%b",
                                 $realtime, got.is_edge, got.keeps);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got != want)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch edge exp %b got %b, safe exp %b got %b",
                                     $realtime, want.is_edge, got.is_edge,
                                     want.keeps, got.keeps);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> verif/tb_edge_flip_clique_check.sv
// testbench top for the edge flip clique check block: clock, reset, request stimulus, verdict
// depends on efcc_pkg, edge_flip_clique_check and efcc_scoreboard
`timescale 1ns / 1ps
module tb_edge_flip_clique_check;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [5:0]  vertex_a;
    logic [5:0]  vertex_b;
    logic [41:0] row_bits;
    logic        done;
    logic        pair_is_edge;
    logic        flip_safe;
    int          errors;
    int          outstanding;
    int          answers;
    int          edge_answers;
    int          idle_pct;
    int          sent;

    edge_flip_clique_check dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .vertex_a(vertex_a), .vertex_b(vertex_b), .row_bits(row_bits),
        .done(done), .pair_is_edge(pair_is_edge), .flip_safe(flip_safe)
    );

    efcc_scoreboard scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .vertex_a(vertex_a), .vertex_b(vertex_b), .row_bits(row_bits),
        .done(done), .pair_is_edge(pair_is_edge), .flip_safe(flip_safe),
        .errors(errors), .outstanding(outstanding), .answers(answers),
        .edge_answers(edge_answers)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #50_000_000;
        $display("tb_edge_flip_clique_check: errors");
        $finish;
    end

    // issue one request and hold it until taken, then maybe idle
    task automatic issue(input efcc_pkg::op_t op, input logic [5:0] a, input logic [5:0] b,
                         input logic [41:0] row);
        start <= 1'b1;
        opcode <= op;
        vertex_a <= a;
        vertex_b <= b;
        row_bits <= row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            opcode <= 2'($urandom);
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // vertex index, mostly valid, sometimes out of range
    function automatic logic [5:0] pick_vertex();
        if ($urandom_range(99) < 3)
            return 6'($urandom_range(42, 63));
        return 6'($urandom_range(0, 41));
    endfunction

    function automatic logic [41:0] pick_row();
        return 42'({$urandom, $urandom});
    endfunction

    initial
    begin
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = efcc_pkg::OP_WRITE;
        vertex_a = '0;
        vertex_b = '0;
        row_bits = '0;
        idle_pct = 0;
        sent = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph, extremes, self pairs, out of range, unused opcode
        issue(efcc_pkg::OP_QUERY, 6'd0, 6'd41, '0);
        issue(efcc_pkg::OP_WRITE, 6'd0, 6'd0, '1);
        issue(efcc_pkg::OP_QUERY, 6'd0, 6'd41, '0);
        issue(efcc_pkg::OP_QUERY, 6'd0, 6'd0, '0);
        issue(efcc_pkg::OP_WRITE, 6'd63, 6'd0, '1);
        issue(efcc_pkg::OP_QUERY, 6'd63, 6'd1, '0);
        issue(efcc_pkg::OP_QUERY, 6'd1, 6'd42, '0);
        issue(efcc_pkg::OP_TOGGLE, 6'd5, 6'd5, '0);
        issue(efcc_pkg::OP_TOGGLE, 6'd5, 6'd63, '0);
        issue(efcc_pkg::OP_NONE, 6'd3, 6'd4, '1);
        // five-clique on 1..5 minus edge (1,2): adding it is unsafe
        issue(efcc_pkg::OP_WRITE, 6'd1, 6'd0, 42'b111000);
        issue(efcc_pkg::OP_WRITE, 6'd2, 6'd0, 42'b111000);
        issue(efcc_pkg::OP_WRITE, 6'd3, 6'd0, 42'b110110);
        issue(efcc_pkg::OP_WRITE, 6'd4, 6'd0, 42'b101110);
        issue(efcc_pkg::OP_WRITE, 6'd5, 6'd0, 42'b011110);
        issue(efcc_pkg::OP_QUERY, 6'd1, 6'd2, '0);
        issue(efcc_pkg::OP_TOGGLE, 6'd1, 6'd2, '0);
        issue(efcc_pkg::OP_QUERY, 6'd2, 6'd1, '0);
        issue(efcc_pkg::OP_QUERY, 6'd3, 6'd4, '0);
        issue(efcc_pkg::OP_WRITE, 6'd41, 6'd0, '0);
        issue(efcc_pkg::OP_QUERY, 6'd41, 6'd40, '0);

        // random phases: no idling, heavy idling, no idling, light idling
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: idle_pct = 47;
                3: idle_pct = 10;
                default: idle_pct = 0;
            endcase
            repeat (410)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                    issue(efcc_pkg::OP_WRITE, pick_vertex(), 6'($urandom), pick_row());
                else if (roll < 55)
                    issue(efcc_pkg::OP_TOGGLE, pick_vertex(), pick_vertex(), pick_row());
                else if (roll < 97)
                    issue(efcc_pkg::OP_QUERY, pick_vertex(), pick_vertex(), pick_row());
                else
                    issue(efcc_pkg::OP_NONE, 6'($urandom), 6'($urandom), pick_row());
            end
        end
        start <= 1'b0;
        @(posedge clk);

        // drain
        while (outstanding != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        $display("sent %0d requests, checked %0d query answers (%0d on edges)",
                 sent, answers, edge_answers);
        if (errors == 0 && outstanding == 0)
            $display("tb_edge_flip_clique_check: clean");
        else
            $display("tb_edge_flip_clique_check: errors");
        $finish;
    end
endmodule
